### hw/rtl/rtsp_pkg.sv
// ----------------------------------------------------------------------------
// Running t statistic peak: shared package
// Types, constants and the controller state and command codes.
// ----------------------------------------------------------------------------
`default_nettype none

package rtsp_pkg;

    localparam int SampleW = 32;
    localparam int IdxW    = 16;
    localparam int AccW    = 64;
    localparam int StepW   = 6;

    localparam logic [IdxW-1:0]    MaxLength = 16'hFFFF;
    localparam logic [SampleW-1:0] MagSat    = 32'h7FFF_FFFF;

    typedef struct packed {
        logic signed [SampleW-1:0] sample;
        logic                      last;
    } t_in;

    typedef struct packed {
        logic signed [SampleW-1:0] peak_stat;
        logic [IdxW-1:0]           peak_index;
        logic                      found;
    } t_out;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_DIV_MEAN,
        ST_MEAN,
        ST_MUL,
        ST_DIV_MSQ,
        ST_MSQ,
        ST_DIV_VAR,
        ST_SQRT,
        ST_DIV_STAT,
        ST_DECIDE
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_DIV_MEAN,
        OP_MEAN,
        OP_MUL,
        OP_DIV_MSQ,
        OP_MSQ,
        OP_DIV_VAR,
        OP_SQRT,
        OP_DIV_STAT,
        OP_DECIDE
    } t_op;

    typedef struct packed {
        t_op  op;
        logic start;
    } t_cmd;

    typedef struct packed {
        logic done;
        logic count_ge2;
        logic sd_zero;
        logic last_eff;
    } t_status;

endpackage

`default_nettype wire

### hw/rtl/rtsp_div.sv
// ----------------------------------------------------------------------------
// Running t statistic peak: shared divider
// Restoring radix-2 divider, 64-bit dividend by 32-bit divisor, 64 steps.
// ----------------------------------------------------------------------------
`default_nettype none

module rtsp_div (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [rtsp_pkg::AccW-1:0]     i_dividend,
    input  wire logic [rtsp_pkg::SampleW-1:0]  i_divisor,
    output logic [rtsp_pkg::AccW-1:0]          o_quotient,
    output logic                               o_done
);
    import rtsp_pkg::*;

    logic                 r_busy;
    logic [StepW-1:0]     r_step;
    logic [SampleW-1:0]   r_rem;
    logic [SampleW-1:0]   r_dvsr;
    logic [AccW-1:0]      r_quot;
    logic [SampleW:0]     shifted;
    logic                 ge;

    assign shifted = {r_rem, r_quot[AccW-1]};
    assign ge      = shifted >= {1'b0, r_dvsr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_step <= '0;
        end else if (r_busy) begin
            r_step <= r_step + 1'b1;
            if (r_step == StepW'(AccW - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvsr <= i_divisor;
            r_quot <= i_dividend;
            r_rem  <= '0;
        end else if (r_busy) begin
            r_rem  <= ge ? SampleW'(shifted - {1'b0, r_dvsr}) : shifted[SampleW-1:0];
            r_quot <= {r_quot[AccW-2:0], ge};
        end
    end

    assign o_quotient = r_quot;
    assign o_done     = r_busy && (r_step == StepW'(AccW - 1));

endmodule

`default_nettype wire

### hw/rtl/rtsp_datapath.sv
// ----------------------------------------------------------------------------
// Running t statistic peak: datapath
// Running mean and mean square, multiplier, square root and peak tracking.
// ----------------------------------------------------------------------------
`default_nettype none

module rtsp_datapath (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire rtsp_pkg::t_cmd                i_cmd,
    input  wire rtsp_pkg::t_in                 i_in,
    input  wire logic                          i_cfg_we,
    input  wire logic [rtsp_pkg::IdxW-1:0]     i_cfg_data,
    output rtsp_pkg::t_status                  o_status,
    output rtsp_pkg::t_out                     o_out
);
    import rtsp_pkg::*;

    logic [IdxW-1:0]            r_min_window;
    logic [IdxW-1:0]            r_count;
    logic signed [SampleW-1:0]  r_mean;
    logic [AccW-1:0]            r_msq;
    logic [SampleW-1:0]         r_best_mag;
    logic                       r_best_neg;
    logic [IdxW-1:0]            r_best_pos;
    logic                       r_have_best;
    logic [SampleW-1:0]         r_prev_mag;
    logic                       r_prev_neg;
    logic                       r_prev_valid;
    logic signed [SampleW-1:0]  r_x;
    logic                       r_last;
    logic signed [SampleW:0]    r_delta;
    logic [AccW-1:0]            r_mcand;
    logic [SampleW:0]           r_mplier;
    logic [AccW-1:0]            r_prod;
    logic [StepW-1:0]           r_cnt;
    logic [AccW-1:0]            r_src;
    logic [SampleW+1:0]         r_srem;
    logic [SampleW-1:0]         r_sd;
    t_out                       r_out;

    logic                       div_start;
    logic [AccW-1:0]            div_dividend;
    logic [SampleW-1:0]         div_divisor;
    logic [AccW-1:0]            div_q;
    logic                       div_done;

    logic [SampleW:0]           abs_delta;
    logic signed [SampleW+1:0]  qs;
    logic signed [SampleW+1:0]  m_new;
    logic signed [SampleW+1:0]  delta2;
    logic                       prod_ge;
    logic [SampleW+1:0]         srem_sh;
    logic [SampleW+1:0]         trial;
    logic                       sqrt_step;
    logic [SampleW-1:0]         am;
    logic [SampleW-1:0]         q_sat;
    logic                       cur_valid;
    logic [SampleW-1:0]         cur_mag;
    logic                       last_eff;
    logic                       ge2;
    logic                       p_en;
    logic                       c_en;
    logic                       b1_have;
    logic [SampleW-1:0]         b1_mag;
    logic                       b1_neg;
    logic [IdxW-1:0]            b1_pos;
    logic                       b2_have;
    logic [SampleW-1:0]         b2_mag;
    logic                       b2_neg;
    logic [IdxW-1:0]            b2_pos;

    rtsp_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_quotient (div_q),
        .o_done     (div_done)
    );

    assign abs_delta = r_delta[SampleW] ? SampleW'(0) - r_delta[SampleW:0] : r_delta[SampleW:0];
    assign prod_ge   = r_prod >= r_msq;
    assign am        = r_mean[SampleW-1] ? SampleW'(0) - r_mean : r_mean;

    always_comb begin
        div_start    = 1'b0;
        div_dividend = '0;
        div_divisor  = {{(SampleW-IdxW){1'b0}}, r_count};
        case (i_cmd.op)
            OP_DIV_MEAN: begin
                div_start    = i_cmd.start;
                div_dividend = AccW'(abs_delta);
            end
            OP_DIV_MSQ: begin
                div_start    = i_cmd.start;
                div_dividend = prod_ge ? r_prod - r_msq : r_msq - r_prod;
            end
            OP_DIV_VAR: begin
                div_start    = i_cmd.start;
                div_dividend = r_msq;
                div_divisor  = {{(SampleW-IdxW){1'b0}}, r_count - 1'b1};
            end
            OP_DIV_STAT: begin
                div_start    = i_cmd.start;
                div_dividend = {{(AccW-SampleW-16){1'b0}}, am, 16'b0};
                div_divisor  = r_sd;
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    assign qs     = r_delta[SampleW] ? -$signed({1'b0, div_q[SampleW:0]})
                                     : $signed({1'b0, div_q[SampleW:0]});
    assign m_new  = $signed({{2{r_mean[SampleW-1]}}, r_mean}) + qs;
    assign delta2 = $signed({{2{r_x[SampleW-1]}}, r_x}) - m_new;

    assign sqrt_step = (i_cmd.op == OP_SQRT) && !i_cmd.start;
    assign srem_sh   = {r_srem[SampleW-1:0], r_src[AccW-1:AccW-2]};
    assign trial     = {r_sd, 2'b01};

    assign ge2      = r_count >= IdxW'(2);
    assign last_eff = r_last || (r_count == MaxLength);
    assign q_sat    = (|div_q[AccW-1:SampleW-1]) ? MagSat : div_q[SampleW-1:0];
    assign cur_valid = ge2 && ((r_sd != '0) || (am != '0));
    assign cur_mag   = (r_sd == '0) ? MagSat : q_sat;

    assign p_en = last_eff && r_prev_valid && (r_count < r_min_window)
               && (r_count >= IdxW'(3));
    assign c_en = cur_valid && (last_eff ||
                  ({1'b0, r_count} + 1'b1 >= {1'b0, r_min_window}));

    always_comb begin
        b1_have = r_have_best;
        b1_mag  = r_best_mag;
        b1_neg  = r_best_neg;
        b1_pos  = r_best_pos;
        if (p_en && (!r_have_best || r_prev_mag > r_best_mag)) begin
            b1_have = 1'b1;
            b1_mag  = r_prev_mag;
            b1_neg  = r_prev_neg;
            b1_pos  = r_count - 1'b1;
        end
        b2_have = b1_have;
        b2_mag  = b1_mag;
        b2_neg  = b1_neg;
        b2_pos  = b1_pos;
        if (c_en && (!b1_have || cur_mag > b1_mag)) begin
            b2_have = 1'b1;
            b2_mag  = cur_mag;
            b2_neg  = r_mean[SampleW-1];
            b2_pos  = r_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_window <= '0;
        end else if (i_cfg_we) begin
            r_min_window <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_mean       <= '0;
            r_msq        <= '0;
            r_best_mag   <= '0;
            r_best_neg   <= 1'b0;
            r_best_pos   <= '0;
            r_have_best  <= 1'b0;
            r_prev_mag   <= '0;
            r_prev_neg   <= 1'b0;
            r_prev_valid <= 1'b0;
        end else begin
            case (i_cmd.op)
                OP_LOAD: begin
                    r_count <= r_count + 1'b1;
                end
                OP_MEAN: begin
                    r_mean <= m_new[SampleW-1:0];
                end
                OP_MSQ: begin
                    r_msq <= prod_ge ? r_msq + div_q : r_msq - div_q;
                end
                OP_DECIDE: begin
                    if (last_eff) begin
                        r_count      <= '0;
                        r_mean       <= '0;
                        r_msq        <= '0;
                        r_best_mag   <= '0;
                        r_best_neg   <= 1'b0;
                        r_best_pos   <= '0;
                        r_have_best  <= 1'b0;
                        r_prev_mag   <= '0;
                        r_prev_neg   <= 1'b0;
                        r_prev_valid <= 1'b0;
                    end else begin
                        r_best_mag   <= b2_mag;
                        r_best_neg   <= b2_neg;
                        r_best_pos   <= b2_pos;
                        r_have_best  <= b2_have;
                        r_prev_mag   <= ge2 ? cur_mag : '0;
                        r_prev_neg   <= ge2 && r_mean[SampleW-1];
                        r_prev_valid <= cur_valid;
                    end
                end
                default: begin
                    r_count <= r_count;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_x     <= i_in.sample;
                r_last  <= i_in.last;
                r_delta <= $signed({i_in.sample[SampleW-1], i_in.sample})
                         - $signed({r_mean[SampleW-1], r_mean});
                r_sd    <= '0;
            end
            OP_MEAN: begin
                r_mcand  <= AccW'(abs_delta);
                r_mplier <= delta2[SampleW+1] ? SampleW'(0) - delta2[SampleW:0]
                                              : delta2[SampleW:0];
                r_prod   <= '0;
                r_cnt    <= '0;
            end
            OP_MUL: begin
                if (r_mplier[0]) begin
                    r_prod <= r_prod + r_mcand;
                end
                r_mcand  <= {r_mcand[AccW-2:0], 1'b0};
                r_mplier <= {1'b0, r_mplier[SampleW:1]};
                r_cnt    <= r_cnt + 1'b1;
            end
            OP_SQRT: begin
                if (i_cmd.start) begin
                    r_src  <= div_q;
                    r_srem <= '0;
                    r_sd   <= '0;
                    r_cnt  <= '0;
                end else if (srem_sh >= trial) begin
                    r_srem <= srem_sh - trial;
                    r_sd   <= {r_sd[SampleW-2:0], 1'b1};
                    r_src  <= {r_src[AccW-3:0], 2'b00};
                    r_cnt  <= r_cnt + 1'b1;
                end else begin
                    r_srem <= srem_sh;
                    r_sd   <= {r_sd[SampleW-2:0], 1'b0};
                    r_src  <= {r_src[AccW-3:0], 2'b00};
                    r_cnt  <= r_cnt + 1'b1;
                end
            end
            OP_DECIDE: begin
                if (last_eff) begin
                    if (r_count == IdxW'(1)) begin
                        r_out.peak_stat  <= '0;
                        r_out.peak_index <= IdxW'(1);
                        r_out.found      <= 1'b1;
                    end else if (b2_have) begin
                        r_out.peak_stat  <= b2_neg ? -$signed(b2_mag) : $signed(b2_mag);
                        r_out.peak_index <= b2_pos;
                        r_out.found      <= 1'b1;
                    end else begin
                        r_out.peak_stat  <= '0;
                        r_out.peak_index <= '0;
                        r_out.found      <= 1'b0;
                    end
                end
            end
            default: begin
                r_cnt <= r_cnt;
            end
        endcase
    end

    always_comb begin
        o_status.count_ge2 = ge2;
        o_status.sd_zero   = (r_sd == '0);
        o_status.last_eff  = last_eff;
        case (i_cmd.op)
            OP_DIV_MEAN, OP_DIV_MSQ, OP_DIV_VAR, OP_DIV_STAT: begin
                o_status.done = div_done;
            end
            OP_MUL: begin
                o_status.done = (r_cnt == StepW'(SampleW));
            end
            OP_SQRT: begin
                o_status.done = sqrt_step && (r_cnt == StepW'(SampleW - 1));
            end
            default: begin
                o_status.done = 1'b0;
            end
        endcase
    end

    assign o_out = r_out;

endmodule

`default_nettype wire

### hw/rtl/rtsp_ctrl.sv
// ----------------------------------------------------------------------------
// Running t statistic peak: controller
// Sequences the datapath per sample and owns both handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module rtsp_ctrl (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    input  wire rtsp_pkg::t_status    i_status,
    output rtsp_pkg::t_cmd            o_cmd
);
    import rtsp_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_entry;
    logic   r_out_valid;
    logic   n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_entry     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_entry     <= n_state != r_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_in_ready  = 1'b0;
        o_cmd.op    = OP_NONE;
        o_cmd.start = r_entry;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = ST_DIV_MEAN;
                end
            end
            ST_DIV_MEAN: begin
                o_cmd.op = OP_DIV_MEAN;
                if (i_status.done) begin
                    n_state = ST_MEAN;
                end
            end
            ST_MEAN: begin
                o_cmd.op = OP_MEAN;
                n_state  = ST_MUL;
            end
            ST_MUL: begin
                o_cmd.op = OP_MUL;
                if (i_status.done) begin
                    n_state = ST_DIV_MSQ;
                end
            end
            ST_DIV_MSQ: begin
                o_cmd.op = OP_DIV_MSQ;
                if (i_status.done) begin
                    n_state = ST_MSQ;
                end
            end
            ST_MSQ: begin
                o_cmd.op = OP_MSQ;
                n_state  = i_status.count_ge2 ? ST_DIV_VAR : ST_DECIDE;
            end
            ST_DIV_VAR: begin
                o_cmd.op = OP_DIV_VAR;
                if (i_status.done) begin
                    n_state = ST_SQRT;
                end
            end
            ST_SQRT: begin
                o_cmd.op = OP_SQRT;
                if (i_status.done) begin
                    n_state = ST_DIV_STAT;
                end
            end
            ST_DIV_STAT: begin
                if (r_entry && i_status.sd_zero) begin
                    n_state = ST_DECIDE;
                end else begin
                    o_cmd.op = OP_DIV_STAT;
                    if (i_status.done) begin
                        n_state = ST_DECIDE;
                    end
                end
            end
            ST_DECIDE: begin
                if (!i_status.last_eff) begin
                    o_cmd.op = OP_DECIDE;
                    n_state  = ST_IDLE;
                end else if (!r_out_valid || i_out_ready) begin
                    o_cmd.op    = OP_DECIDE;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

### hw/rtl/running_t_statistic_peak.sv
// ----------------------------------------------------------------------------
// Running t statistic peak
// Streams Q16.16 samples and reports the peak one-sample t statistic of each
// stream.
//
// The input channel carries one sample and a last flag per transaction. The
// output channel carries one transaction per stream: the signed peak
// statistic, its 1-based index and a found flag. Both channels use valid and
// ready. The user must write the min_window register through i_cfg_we and
// i_cfg_data only while the block is idle; the block does not enforce this.
// Each sample is worked on alone by a controller and a datapath. The first
// sample of a stream makes two passes through the shared 64-step divider and
// one through a 33-step shift-add multiplier; later samples add up to two
// more divider passes and a 32-step square root.
// The result transaction is held in an output register, so the next sample
// is taken while it waits; if it is still not taken when the following
// stream ends, the block waits for the receiver. Reset clears the stream
// state, the min_window register and the output valid.
// ----------------------------------------------------------------------------
`default_nettype none

module running_t_statistic_peak (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    output logic                            o_in_ready,
    input  wire rtsp_pkg::t_in              i_in,
    output logic                            o_out_valid,
    input  wire logic                       i_out_ready,
    output rtsp_pkg::t_out                  o_out,
    input  wire logic                       i_cfg_we,
    input  wire logic [rtsp_pkg::IdxW-1:0]  i_cfg_data
);
    import rtsp_pkg::*;

    t_cmd    cmd;
    t_status status;

    rtsp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    rtsp_datapath u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_in       (i_in),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .o_status   (status),
        .o_out      (o_out)
    );

endmodule

`default_nettype wire

### verif/running_t_statistic_peak_tb.sv
// ----------------------------------------------------------------------------
// Running t statistic peak: testbench
// Streams of Q16.16 samples are sent under several min_window settings, with
// random gaps on both channels. A scoreboard recomputes the peak statistic of
// each stream and compares every output transaction field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module running_t_statistic_peak_tb;
    import rtsp_pkg::*;

    class peak_scoreboard;
        bit [15:0]   window;
        int unsigned n_samples;
        longint      mean;
        bit [63:0]   msq;
        bit [31:0]   best_mag;
        bit          best_neg;
        int unsigned best_pos;
        bit          best_ok;
        bit [31:0]   prev_mag;
        bit          prev_neg;
        bit          prev_ok;
        t_out        peaks_due[$];
        int          n_errors;

        function new();
            window   = '0;
            n_errors = 0;
            clear();
        endfunction

        function void clear();
            n_samples = 0;
            mean      = 0;
            msq       = '0;
            best_mag  = '0;
            best_neg  = 1'b0;
            best_pos  = 0;
            best_ok   = 1'b0;
            prev_mag  = '0;
            prev_neg  = 1'b0;
            prev_ok   = 1'b0;
        endfunction

        function bit [63:0] root_floor(bit [63:0] v);
            bit [63:0] res;
            bit [63:0] b;
            res = '0;
            b   = 64'd1 << 62;
            while (b > v) b = b >> 2;
            while (b != 0) begin
                if (v >= res + b) begin
                    v   = v - (res + b);
                    res = (res >> 1) + b;
                end else begin
                    res = res >> 1;
                end
                b = b >> 2;
            end
            return res;
        endfunction

        function void offer(bit ok, bit [31:0] mag, bit neg, int unsigned pos);
            if (ok && (!best_ok || mag > best_mag)) begin
                best_ok  = 1'b1;
                best_mag = mag;
                best_neg = neg;
                best_pos = pos;
            end
        endfunction

        function void note_sample(t_in it);
            longint      x, delta, delta2, m, idx;
            bit [63:0]   ad, ad2, prod, sd, am, q;
            bit          fin, ok, neg;
            bit [31:0]   mag;
            t_out        r;
            x = longint'(it.sample);
            n_samples++;
            idx = n_samples;
            fin = it.last || (n_samples >= 65535);
            ok  = 1'b0;
            neg = 1'b0;
            mag = '0;
            delta  = x - mean;
            m      = mean + delta / idx;
            mean   = m;
            delta2 = x - m;
            ad   = (delta < 0) ? -delta : delta;
            ad2  = (delta2 < 0) ? -delta2 : delta2;
            prod = ad * ad2;
            if (prod >= msq) msq = msq + (prod - msq) / idx;
            else msq = msq - (msq - prod) / idx;
            if (n_samples >= 2) begin
                sd  = root_floor(msq / (idx - 1));
                am  = (m < 0) ? -m : m;
                neg = m < 0;
                if (sd == 0) begin
                    if (am != 0) begin
                        ok  = 1'b1;
                        mag = MagSat;
                    end
                end else begin
                    q   = (am << 16) / sd;
                    ok  = 1'b1;
                    mag = (q > 64'h7FFF_FFFF) ? MagSat : q[31:0];
                end
            end
            if (!fin) begin
                if (n_samples >= 2 && n_samples + 1 >= window)
                    offer(ok, mag, neg, n_samples);
                prev_ok  = ok;
                prev_mag = mag;
                prev_neg = neg;
                return;
            end
            if (n_samples == 1) begin
                r.peak_stat  = '0;
                r.peak_index = 16'd1;
                r.found      = 1'b1;
            end else begin
                if (n_samples < window && n_samples - 1 >= 2)
                    offer(prev_ok, prev_mag, prev_neg, n_samples - 1);
                offer(ok, mag, neg, n_samples);
                if (best_ok) begin
                    r.peak_stat  = best_neg ? -best_mag : best_mag;
                    r.peak_index = best_pos[15:0];
                    r.found      = 1'b1;
                end else begin
                    r = '0;
                end
            end
            peaks_due.push_back(r);
            clear();
        endfunction

        task report(string what, longint got, longint want);
            $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
            n_errors++;
        endtask

        task check_peak(t_out got);
            t_out want;
            if (peaks_due.size() == 0) begin
                report("unexpected transaction", got, 0);
                return;
            end
            want = peaks_due.pop_front();
            if (got.peak_stat !== want.peak_stat)
                report("peak_stat", got.peak_stat, want.peak_stat);
            if (got.peak_index !== want.peak_index)
                report("peak_index", got.peak_index, want.peak_index);
            if (got.found !== want.found) report("found", got.found, want.found);
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    t_in         i_in;
    logic        o_out_valid;
    logic        i_out_ready;
    t_out        o_out;
    logic        i_cfg_we;
    logic [15:0] i_cfg_data;

    peak_scoreboard sb;
    bit             calm;
    int             quiet_cycles;

    running_t_statistic_peak u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in       (i_in),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out      (o_out),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function int draw_gap();
        return calm ? 0 : $urandom_range(0, 14);
    endfunction

    task send_sample(logic [31:0] value, bit fin);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= '{sample: value, last: fin};
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_sample('{sample: value, last: fin});
    endtask

    task send_stream(int len, int flavour);
        logic [31:0] base, v;
        base = $urandom;
        for (int k = 0; k < len; k++) begin
            case (flavour)
                0: v = $urandom;
                1: v = $urandom_range(0, 32'h0003_FFFF) - 32'h0002_0000;
                2: v = base + $urandom_range(0, 3) - 1;
                default: v = base;
            endcase
            send_sample(v, k == len - 1);
        end
    endtask

    task drain();
        i_in_valid <= 1'b0;
        while (sb.peaks_due.size() > 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
    endtask

    task write_window(logic [15:0] value);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        sb.window = value;
    endtask

    initial begin
        sb          = new();
        calm        = 1'b0;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in        = '0;
        i_out_ready = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_data  = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_sample(32'h0001_0000, 1'b1);
        send_sample(32'h8000_0000, 1'b1);
        send_sample(32'd0, 1'b0);
        send_sample(32'd0, 1'b0);
        send_sample(32'd0, 1'b1);
        send_sample(32'h0003_0000, 1'b0);
        send_sample(32'h0003_0000, 1'b1);
        send_sample(32'h8000_0000, 1'b0);
        send_sample(32'h7FFF_FFFF, 1'b1);
        send_sample(32'h7FFF_FFFF, 1'b0);
        send_sample(32'h7FFF_FFFE, 1'b0);
        send_sample(32'h7FFF_FFFF, 1'b1);
        send_sample(32'hFFFF_0000, 1'b0);
        send_sample(32'hFFFE_FFFF, 1'b0);
        send_sample(32'hFFFF_0000, 1'b1);
        send_sample(32'h0000_0001, 1'b0);
        send_sample(32'hFFFF_FFFF, 1'b0);
        send_sample(32'h0000_0001, 1'b0);
        send_sample(32'hFFFF_FFFF, 1'b1);
        drain();

        for (int ph = 0; ph < 9; ph++) begin
            int sent;
            logic [15:0] w;
            case (ph)
                0: w = 16'd0;
                1: w = 16'd1;
                2: w = 16'd2;
                3: w = 16'd3;
                4: w = 16'd5;
                5: w = 16'd9;
                6: w = 16'hFFFF;
                7: w = 16'($urandom_range(0, 14));
                default: w = 16'($urandom);
            endcase
            write_window(w);
            calm = (ph == 3);
            sent = 0;
            while (sent < 175) begin
                int len;
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 30)
                                                 : $urandom_range(1, 12);
                send_stream(len, $urandom_range(0, 3));
                sent += len;
                if (ph == 4 && sent > 80 && sent - len <= 80) begin
                    i_in_valid <= 1'b0;
                    while (sb.peaks_due.size() > 0) @(posedge i_clk);
                end
            end
            drain();
        end

        if (sb.n_errors == 0 && sb.peaks_due.size() == 0) begin
            $display("running_t_statistic_peak_tb: clean");
        end else begin
            $display("running_t_statistic_peak_tb: errors");
        end
        $finish;
    end

    initial begin
        t_out got;
        @(posedge i_rst_n);
        forever begin
            int gap;
            gap = draw_gap();
            if (gap > 0) begin
                i_out_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            got = o_out;
            sb.check_peak(got);
        end
    end

    initial begin
        quiet_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= 20000) begin
                $display("running_t_statistic_peak_tb: errors");
                $finish;
            end
        end
    end

endmodule

### filelist.f
hw/rtl/rtsp_pkg.sv
hw/rtl/rtsp_div.sv
hw/rtl/rtsp_datapath.sv
hw/rtl/rtsp_ctrl.sv
hw/rtl/running_t_statistic_peak.sv
verif/running_t_statistic_peak_tb.sv
